### src/sparse_transpose_gather_dot_defines.svh
// Assertion macros shared by the sparse gather dot-product RTL.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef SPARSE_TRANSPOSE_GATHER_DOT_DEFINES_SVH
`define SPARSE_TRANSPOSE_GATHER_DOT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STGD_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define STGD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### src/stgd_pkg.sv
// Package for the sparse gather dot-product block: command codes and
// fixed field widths. No dependencies.
package stgd_pkg;

  localparam int INDEX_W    = 12;
  localparam int IN_VALUE_W = 32;
  localparam int LENGTH_W   = 13;
  localparam int SUM_W      = 64;
  localparam int COLUMN_W   = 16;
  localparam int CMD_W      = 2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TERM  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

endpackage

### src/stgd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module stgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sparse_transpose_gather_dot.sv
// Sparse gather dot product: dense vector store plus saturating Q32.32 MAC.
// Depends on stgd_pkg, stgd_ram and sparse_transpose_gather_dot_defines.svh.
//
//  channel | dir | signals                          | moves
//  --------+-----+----------------------------------+------------------------------
//  s_      | in  | tvalid tready tdata tuser tlast  | load, term or close transfers
//  m_      | out | tvalid tready tdata              | finished column results
//  cfg_    | in  | wen wdata                        | vector_length register write
//
//  One transfer per cycle while s_tready is high. A column result lands in the output
//  register after its closing transfer: store read at acceptance, multiply, accumulate.
//  s_tready drops only while a result waits unread and another finishing item
//  sits in the accumulate stage. Synchronous reset clears sum, counter, length
//  and pipeline valids; the vector store holds no reset and needs no clearing.
module sparse_transpose_gather_dot #(
  parameter int VECTOR_DEPTH = 4096,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_wen,
  input  logic [stgd_pkg::LENGTH_W-1:0]          cfg_wdata,   // vector_length
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [47:0]                            s_tdata,     // [11:0] index, [43:12] value
  input  logic [stgd_pkg::CMD_W-1:0]             s_tuser,     // [1:0] command
  input  logic                                   s_tlast,     // last term of column
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [79:0]                            m_tdata      // [63:0] dot_value,
                                                              // [79:64] column_number
);
  import stgd_pkg::*;

  `include "sparse_transpose_gather_dot_defines.svh"

  localparam int ADDR_W = $clog2(VECTOR_DEPTH);
  // compare width: holds the store depth itself, the index and the length
  localparam int CMP_A  = (ADDR_W + 1 > INDEX_W) ? ADDR_W + 1 : INDEX_W;
  localparam int CMP_W  = (CMP_A > LENGTH_W) ? CMP_A : LENGTH_W;
  localparam int PROD_W = 2 * VALUE_WIDTH;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(VECTOR_DEPTH);

  // unpack the input transfer
  logic [INDEX_W-1:0]    in_index;
  logic [IN_VALUE_W-1:0] in_value;
  cmd_t                  in_cmd;
  assign in_index = s_tdata[INDEX_W-1:0];
  assign in_value = s_tdata[INDEX_W +: IN_VALUE_W];
  assign in_cmd   = cmd_t'(s_tuser);

  // usable length = min(vector_length, depth), settled at the config write
  logic [CMP_W-1:0] usable_length;
  logic [CMP_W-1:0] cfg_ext;
  assign cfg_ext = CMP_W'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_length <= '0;
    end else if (cfg_wen) begin
      usable_length <= (cfg_ext < DEPTH_C) ? cfg_ext : DEPTH_C;
    end
  end

  // pipeline control
  logic accept;
  logic stall;
  logic p1_valid, p1_add, p1_fin;
  logic p2_valid, p2_add, p2_fin;
  logic signed [VALUE_WIDTH-1:0] p1_weight;
  logic signed [SUM_W-1:0]       p2_prod;

  // hold everything when a finish would overwrite an unread result
  assign stall    = m_tvalid && !m_tready && p2_valid && p2_fin;
  assign s_tready = !stall;
  assign accept   = s_tvalid && s_tready;

  // decode the accepted transfer
  logic [CMP_W-1:0] idx_ext;
  logic             in_store, in_range;
  logic             dec_load, dec_add, dec_fin;
  assign idx_ext  = CMP_W'(in_index);
  assign in_store = idx_ext < DEPTH_C;
  assign in_range = idx_ext < usable_length;

  always_comb begin
    dec_load = 1'b0;
    dec_add  = 1'b0;
    dec_fin  = 1'b0;
    case (in_cmd)
      CMD_LOAD: begin
        dec_load = in_store;
      end
      CMD_TERM: begin
        dec_add = in_range;
        dec_fin = s_tlast;
      end
      CMD_CLOSE: begin
        dec_fin = 1'b1;
      end
      default: begin
        // unused command: drop
      end
    endcase
  end

  // vector store: load writes, term reads; a load and a term never share an
  // edge and the write lands before any later read, so no forwarding
  logic [VALUE_WIDTH-1:0] ram_rdata;

  stgd_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (VECTOR_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && dec_load),
    .waddr (idx_ext[ADDR_W-1:0]),
    .wdata (in_value[VALUE_WIDTH-1:0]),
    .re    (accept && dec_add),
    .raddr (idx_ext[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // stage 1: store read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (!stall) begin
      p1_valid <= accept && (dec_add || dec_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      p1_add    <= dec_add;
      p1_fin    <= dec_fin;
      p1_weight <= signed'(in_value[VALUE_WIDTH-1:0]);
    end
  end

  // stage 2: multiply weight by stored entry, exact product
  logic signed [PROD_W-1:0] prod;
  assign prod = p1_weight * signed'(ram_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (!stall) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      p2_add  <= p1_add;
      p2_fin  <= p1_fin;
      p2_prod <= p1_add ? SUM_W'(prod) : '0;
    end
  end

  // stage 3: saturating accumulate and emit
  logic signed [SUM_W-1:0] running_sum;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SUM_W:0]   sum_wide;
  logic [COLUMN_W-1:0]     column_counter;
  logic [COLUMN_W-1:0]     column_inc;
  logic                    advance_fin;

  assign sum_wide = {running_sum[SUM_W-1], running_sum} + {p2_prod[SUM_W-1], p2_prod};
  assign column_inc = column_counter + COLUMN_W'(1);

  always_comb begin
    sum_next = running_sum;
    if (p2_valid && p2_add) begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
        sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        sum_next = sum_wide[SUM_W-1:0];
      end
    end
  end

  assign advance_fin = p2_valid && p2_fin && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      column_counter <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (!stall) begin
        running_sum <= advance_fin ? '0 : sum_next;
      end
      if (advance_fin) begin
        column_counter <= column_inc;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance_fin) begin
      m_tdata <= {column_counter, sum_next};
    end
  end

  // checks
  `STGD_ASSERT_NEXT(a_fin_loads_output, advance_fin, m_tvalid && running_sum == '0, "no load")
  `STGD_ASSERT_NEXT(a_col_advance, advance_fin, column_counter == $past(column_inc), "no step")
  `STGD_ASSERT_NEXT(a_out_drains, m_tvalid && m_tready && !advance_fin, !m_tvalid, "stuck")
  `STGD_ASSERT_NEXT(a_stall_holds_p2, stall, p2_valid && p2_fin, "finish moved")
  `STGD_ASSERT_IMPL(a_no_load_in_flight, p1_valid && !p1_add && !p1_fin, 1'b0, "empty item")

endmodule
